### rtl/cfr_pkg.sv
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared types, codes and the CRC-16 byte update for the frame receiver.
// ----------------------------------------------------------------------------
package cfr_pkg;

  // Frame layout
  localparam int POS_W    = 9;
  localparam logic [POS_W-1:0] HDR_BYTES = 9'd8;
  localparam logic [POS_W-1:0] POS_MAX   = 9'h1FF;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // Register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_SYNC_FIRST  = 2'd0,
    REG_SYNC_SECOND = 2'd1,
    REG_CRC_POLY    = 2'd2
  } reg_index_t;

  // Verdict codes
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_TOO_SHORT = 2'd1,
    STATUS_BAD_SYNC  = 2'd2,
    STATUS_CRC_ERR   = 2'd3
  } frame_status_t;

  // Result beat kinds
  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_VERDICT = 1'b1
  } result_kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  payload_data;
    logic [1:0]  frame_status;
    logic [7:0]  source_node;
    logic [7:0]  dest_node;
    logic [7:0]  message_type;
    logic [15:0] message_id;
    logic [7:0]  payload_length;
    logic [15:0] received_crc;
  } out_beat_t;

  typedef struct packed {
    logic [7:0]  sync_first_byte;
    logic [7:0]  sync_second_byte;
    logic [15:0] crc_polynomial;
  } cfg_regs_t;

  // CRC-16, MSB first, one byte per call (eight shift/xor steps)
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                           input logic [7:0]  data,
                                           input logic [15:0] poly);
    logic [15:0] crc;
    crc = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (crc[15]) begin
        crc = {crc[14:0], 1'b0} ^ poly;
      end else begin
        crc = {crc[14:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

### rtl/cfr_in_reg.sv
// ----------------------------------------------------------------------------
// cfr_in_reg
// Input register: captures one byte beat and holds it until the engine takes it.
// ----------------------------------------------------------------------------
module cfr_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  cfr_pkg::in_beat_t in_data,
  output logic              item_valid,
  output cfr_pkg::in_beat_t item,
  input  logic              item_take
);
  import cfr_pkg::*;

  // Accept when empty or when the held beat leaves this cycle
  assign in_ready = !item_valid || item_take;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  // Load payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
  end

endmodule

### rtl/cfr_frame_engine.sv
// ----------------------------------------------------------------------------
// cfr_frame_engine
// Frame parser: tracks byte position, header fields and running CRC, and
// writes payload or verdict beats into the result register.
// ----------------------------------------------------------------------------
module cfr_frame_engine (
  input  logic               clk,
  input  logic               rst,
  input  cfr_pkg::cfg_regs_t cfg,
  input  logic               item_valid,
  input  cfr_pkg::in_beat_t  item,
  output logic               item_take,
  output logic               out_valid,
  input  logic               out_ready,
  output cfr_pkg::out_beat_t out_data
);
  import cfr_pkg::*;

  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [15:0]      running_crc, running_crc_next;
  logic [7:0]       held_source, held_source_next;
  logic [7:0]       held_dest, held_dest_next;
  logic [7:0]       held_msg_type, held_msg_type_next;
  logic [15:0]      held_msg_id, held_msg_id_next;
  logic [7:0]       held_payload_len, held_payload_len_next;
  logic [7:0]       crc_low_byte, crc_low_byte_next;
  logic             verdict_given, verdict_given_next;

  logic             has_result;
  logic             res_kind;
  logic [7:0]       res_payload;
  logic [1:0]       res_status;
  logic [15:0]      res_crc;
  logic [POS_W-1:0] frame_end;
  logic [15:0]      crc_updated;
  logic [15:0]      rx_crc;
  logic             sync_bad;
  logic [7:0]       b;
  logic             last;

  // Process a beat whenever the result register can take one
  assign item_take = item_valid && (!out_valid || out_ready);

  assign b           = item.data_byte;
  assign last        = item.last_byte;
  assign crc_updated = crc_feed(running_crc, b, cfg.crc_polynomial);
  assign rx_crc      = {b, crc_low_byte};

  // Next frame state and result for the held beat
  always_comb begin
    byte_position_next    = byte_position;
    running_crc_next      = running_crc;
    held_source_next      = held_source;
    held_dest_next        = held_dest;
    held_msg_type_next    = held_msg_type;
    held_msg_id_next      = held_msg_id;
    held_payload_len_next = held_payload_len;
    crc_low_byte_next     = crc_low_byte;
    verdict_given_next    = verdict_given;
    has_result            = 1'b0;
    res_kind              = KIND_VERDICT;
    res_payload           = 8'h00;
    res_status            = STATUS_OK;
    res_crc               = 16'h0000;
    frame_end             = HDR_BYTES + {1'b0, held_payload_len};
    sync_bad              = 1'b0;

    if (verdict_given) begin
      // Drop trailing bytes until the buffer ends
      if (last) begin
        byte_position_next = '0;
        running_crc_next   = CRC_INIT;
        verdict_given_next = 1'b0;
      end
    end else begin
      // Clear header holds at the start of a buffer
      if (byte_position == '0) begin
        held_source_next      = 8'h00;
        held_dest_next        = 8'h00;
        held_msg_type_next    = 8'h00;
        held_msg_id_next      = 16'h0000;
        held_payload_len_next = 8'h00;
        crc_low_byte_next     = 8'h00;
        frame_end             = HDR_BYTES;
      end

      sync_bad = (byte_position == 9'd0 && b != cfg.sync_first_byte) ||
                 (byte_position == 9'd1 && b != cfg.sync_second_byte);

      priority if (sync_bad) begin
        has_result = 1'b1;
        res_status = STATUS_BAD_SYNC;
      end else if (byte_position < HDR_BYTES) begin
        // Capture header fields
        unique case (byte_position[2:0])
          3'd2:    held_source_next      = b;
          3'd3:    held_dest_next        = b;
          3'd4:    held_msg_type_next    = b;
          3'd5:    held_msg_id_next      = {held_msg_id[15:8], b};
          3'd6:    held_msg_id_next      = {b, held_msg_id[7:0]};
          3'd7:    held_payload_len_next = b;
          default: ;
        endcase
        running_crc_next = crc_updated;
        if (last) begin
          has_result = 1'b1;
          res_status = STATUS_TOO_SHORT;
        end
      end else if (byte_position < frame_end) begin
        // Pass payload through, or cut short on an early end
        running_crc_next = crc_updated;
        has_result       = 1'b1;
        if (last) begin
          res_status = STATUS_TOO_SHORT;
        end else begin
          res_kind    = KIND_PAYLOAD;
          res_payload = b;
        end
      end else if (byte_position == frame_end) begin
        crc_low_byte_next = b;
        if (last) begin
          has_result = 1'b1;
          res_status = STATUS_TOO_SHORT;
        end
      end else begin
        // Final CRC byte: compare trailer against running CRC
        has_result = 1'b1;
        res_crc    = rx_crc;
        res_status = (rx_crc == running_crc) ? STATUS_OK : STATUS_CRC_ERR;
      end

      if (last) begin
        byte_position_next = '0;
        running_crc_next   = CRC_INIT;
        verdict_given_next = 1'b0;
      end else begin
        if (has_result && res_kind == KIND_VERDICT) begin
          verdict_given_next = 1'b1;
        end
        if (byte_position != POS_MAX) begin
          byte_position_next = byte_position + 9'd1;
        end
      end
    end
  end

  // Update frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      running_crc      <= CRC_INIT;
      held_source      <= 8'h00;
      held_dest        <= 8'h00;
      held_msg_type    <= 8'h00;
      held_msg_id      <= 16'h0000;
      held_payload_len <= 8'h00;
      crc_low_byte     <= 8'h00;
      verdict_given    <= 1'b0;
    end else if (item_take) begin
      byte_position    <= byte_position_next;
      running_crc      <= running_crc_next;
      held_source      <= held_source_next;
      held_dest        <= held_dest_next;
      held_msg_type    <= held_msg_type_next;
      held_msg_id      <= held_msg_id_next;
      held_payload_len <= held_payload_len_next;
      crc_low_byte     <= crc_low_byte_next;
      verdict_given    <= verdict_given_next;
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (item_take && has_result) begin
        out_valid <= 1'b1;
      end
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (item_take && has_result) begin
      out_data.result_kind    <= res_kind;
      out_data.payload_data   <= res_payload;
      out_data.frame_status   <= res_status;
      out_data.source_node    <= held_source_next;
      out_data.dest_node      <= held_dest_next;
      out_data.message_type   <= held_msg_type_next;
      out_data.message_id     <= held_msg_id_next;
      out_data.payload_length <= held_payload_len_next;
      out_data.received_crc   <= res_crc;
    end
  end

endmodule

### rtl/crc16_frame_receiver_core.sv
// A byte waits in the input register until the engine takes it; its result is registered.
// Throughput: one byte per cycle when the result port is not stalled; the CRC update is eight
//   shift/xor steps unrolled between the input register and the running CRC register.
// A byte that gives no result (sync, header, CRC low byte, trailing) also waits on a stall.
// Reset (rst, synchronous): clears frame state, CRC to 0xFFFF, empties both
//   registers, loads sync bytes 0x00 and polynomial 0x1021.
// ----------------------------------------------------------------------------
// crc16_frame_receiver_core
// Byte-stream frame receiver with sync check, header capture and CRC-16 check.
// ----------------------------------------------------------------------------
module crc16_frame_receiver_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  cfr_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cfr_pkg::out_beat_t out_data
);
  import cfr_pkg::*;

  cfg_regs_t cfg;
  logic      item_valid;
  in_beat_t  item;
  logic      item_take;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_first_byte  <= 8'h00;
      cfg.sync_second_byte <= 8'h00;
      cfg.crc_polynomial   <= 16'h1021;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_SYNC_FIRST:  cfg.sync_first_byte  <= cfg_data[7:0];
        REG_SYNC_SECOND: cfg.sync_second_byte <= cfg_data[7:0];
        REG_CRC_POLY:    cfg.crc_polynomial   <= cfg_data;
        default: ;
      endcase
    end
  end

  cfr_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  cfr_frame_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

### rtl/cfr_checker.sv
// ----------------------------------------------------------------------------
// cfr_checker
// Port-level checks on the frame receiver's result beats.
// ----------------------------------------------------------------------------
module cfr_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input cfr_pkg::out_beat_t out_data
);
  import cfr_pkg::*;

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // Payload beats carry no status and no trailer CRC
  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.result_kind == KIND_PAYLOAD |->
      out_data.frame_status == STATUS_OK && out_data.received_crc == 16'h0000)
    else $error("payload beat carries verdict fields");

  // Early-end and sync verdicts carry no trailer CRC
  a_short_no_crc: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.result_kind == KIND_VERDICT &&
    (out_data.frame_status == STATUS_TOO_SHORT ||
     out_data.frame_status == STATUS_BAD_SYNC) |->
      out_data.received_crc == 16'h0000 && out_data.payload_data == 8'h00)
    else $error("short or sync verdict carries data");

  // Sync fails before any header field is captured
  a_sync_no_header: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.result_kind == KIND_VERDICT &&
    out_data.frame_status == STATUS_BAD_SYNC |->
      out_data.source_node == 8'h00 && out_data.dest_node == 8'h00 &&
      out_data.message_type == 8'h00 && out_data.message_id == 16'h0000 &&
      out_data.payload_length == 8'h00)
    else $error("bad sync verdict shows header fields");

  // No result beat right after reset
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("result beat present after reset");

endmodule

bind crc16_frame_receiver_core cfr_checker u_cfr_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
